// ===== sv/tree_lowest_common_ancestor_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the tree lowest common ancestor core
// Shared property templates used by the port checker.
// ---------------------------------------------------------------------------
`ifndef TREE_LOWEST_COMMON_ANCESTOR_CORE_DEFINES_SVH
`define TREE_LOWEST_COMMON_ANCESTOR_CORE_DEFINES_SVH

// Next-cycle implication, disabled while reset is asserted.
`define TLCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define TLCA_ASSERT_NEXT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/tlca_pkg.sv =====
// ---------------------------------------------------------------------------
// Tree LCA package
// Shared constants, controller states and the command and status structs.
// ---------------------------------------------------------------------------
`default_nettype none

package tlca_pkg;

    // Width of a node id on the ports and in the tables.
    localparam int ID_W = 10;

    // Request item command codes.
    typedef enum logic {
        CMD_LINK  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_B0_RD,
        S_B0_WR,
        S_BK_RD1,
        S_BK_RD2,
        S_BK_WR,
        S_D_INIT,
        S_D_RD,
        S_D_STEP,
        S_D_WR,
        S_Q_DA,
        S_Q_DB,
        S_Q_SW,
        S_L_CHK,
        S_L_UPD,
        S_M_CHK,
        S_M_RDA,
        S_M_RDB,
        S_M_CMP,
        S_M_FIN,
        S_M_RES,
        S_RESULT
    } t_state;

    // Ancestor table read address selection.
    typedef enum logic [2:0] {
        T_NONE,
        T_PREV_V,
        T_PREV_MID,
        T_CUR,
        T_A,
        T_B,
        T_A_LVL0
    } t_tsel;

    // Level counter update.
    typedef enum logic [2:0] {
        K_HOLD,
        K_ZERO,
        K_ONE,
        K_TOP,
        K_INC,
        K_DEC
    } t_ksel;

    // Result register update.
    typedef enum logic [1:0] {
        R_HOLD,
        R_ZERO,
        R_A,
        R_TAB
    } t_rsel;

    typedef struct packed {
        logic  take;
        logic  clr_wr;
        logic  edge_wr;
        logic  par_rd;
        t_tsel tab_rd;
        logic  tab_wr0;
        logic  tab_wrk;
        logic  dep_rd_a;
        logic  dep_rd_b;
        logic  dep_wr;
        logic  v_one;
        logic  v_inc;
        t_ksel k_op;
        logic  mid_ld;
        logic  ta_ld;
        logic  da_ld;
        logic  swap;
        logic  d_init;
        logic  d_step;
        logic  lift_upd;
        logic  match_upd;
        logic  set_built;
        t_rsel res_op;
        logic  out_load;
    } t_ctrl;

    typedef struct packed {
        logic in_fire;
        logic clr_last;
        logic v_last;
        logic k_last;
        logic k_zero;
        logic is_query;
        logic ids_ok;
        logic built;
        logic diff_bit;
        logic a_zero;
        logic a_eq_b;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== sv/tlca_req_if.sv =====
// ---------------------------------------------------------------------------
// Tree LCA request channel
// Valid/ready channel carrying one edge or query item.
// ---------------------------------------------------------------------------
`default_nettype none

interface tlca_req_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [tlca_pkg::ID_W-1:0] node_a;
    logic [tlca_pkg::ID_W-1:0] node_b;

    modport source (output valid, cmd, node_a, node_b, input ready);
    modport sink (input valid, cmd, node_a, node_b, output ready);
endinterface

`default_nettype wire

// ===== sv/tlca_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Tree LCA response channel
// Valid/ready channel carrying one common ancestor item.
// ---------------------------------------------------------------------------
`default_nettype none

interface tlca_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [tlca_pkg::ID_W-1:0] common_ancestor;

    modport source (output valid, common_ancestor, input ready);
    modport sink (input valid, common_ancestor, output ready);
endinterface

`default_nettype wire

// ===== sv/tree_lowest_common_ancestor_core.sv =====
// One item is in work at a time; the next is taken once the current one is done.
// A valid query after a valid edge or a count write first rebuilds the tables,
// reading each lower level through the single read port of the ancestor table RAM.
// Reset is synchronous, active low; afterwards a clearing pass over every node
// zeroes the parent store and no item is taken until it ends.
// ---------------------------------------------------------------------------
// Tree lowest common ancestor core
// Binary lifting engine: edge items fill a parent store, queries return the
// lowest common ancestor of two nodes.
// ---------------------------------------------------------------------------
`default_nettype none

module tree_lowest_common_ancestor_core #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [tlca_pkg::ID_W-1:0] i_cfg_wdata,
    tlca_req_if.sink                       i_req,
    tlca_rsp_if.source                     o_rsp
);

    tlca_pkg::t_ctrl ctl;
    tlca_pkg::t_stat stat;

    // Sequencer.
    tlca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    // Stores and walk registers.
    tlca_datapath #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (i_req.valid),
        .i_req_cmd   (i_req.cmd),
        .i_req_a     (i_req.node_a),
        .i_req_b     (i_req.node_b),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_out_data  (o_rsp.common_ancestor)
    );

    assign i_req.ready = ctl.take;

endmodule

`default_nettype wire

// ===== sv/tlca_ram.sv =====
// ---------------------------------------------------------------------------
// Tree LCA generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tlca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// ===== sv/tlca_ctrl.sv =====
// ---------------------------------------------------------------------------
// Tree LCA controller
// Sequences the clearing pass, edge writes, the table build and the query walk.
// ---------------------------------------------------------------------------
`default_nettype none

module tlca_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tlca_pkg::t_stat i_stat,
    output tlca_pkg::t_ctrl      o_ctl
);

    tlca_pkg::t_state r_state;
    tlca_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlca_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            tlca_pkg::S_CLEAR: begin
                o_ctl.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = tlca_pkg::S_IDLE;
                end
            end
            tlca_pkg::S_IDLE: begin
                o_ctl.take = 1'b1;
                if (i_stat.in_fire) begin
                    n_state = tlca_pkg::S_DECODE;
                end
            end
            tlca_pkg::S_DECODE: begin
                priority if (!i_stat.is_query) begin
                    o_ctl.edge_wr = i_stat.ids_ok;
                    n_state       = tlca_pkg::S_IDLE;
                end else if (!i_stat.ids_ok) begin
                    o_ctl.res_op = tlca_pkg::R_ZERO;
                    n_state      = tlca_pkg::S_RESULT;
                end else if (!i_stat.built) begin
                    o_ctl.v_one = 1'b1;
                    o_ctl.k_op  = tlca_pkg::K_ZERO;
                    n_state     = tlca_pkg::S_B0_RD;
                end else begin
                    n_state = tlca_pkg::S_Q_DA;
                end
            end
            // Level zero comes straight from the parent store.
            tlca_pkg::S_B0_RD: begin
                o_ctl.par_rd = 1'b1;
                n_state      = tlca_pkg::S_B0_WR;
            end
            tlca_pkg::S_B0_WR: begin
                o_ctl.tab_wr0 = 1'b1;
                if (i_stat.v_last) begin
                    o_ctl.v_one = 1'b1;
                    o_ctl.k_op  = tlca_pkg::K_ONE;
                    n_state     = tlca_pkg::S_BK_RD1;
                end else begin
                    o_ctl.v_inc = 1'b1;
                    n_state     = tlca_pkg::S_B0_RD;
                end
            end
            // Each higher level doubles the previous one.
            tlca_pkg::S_BK_RD1: begin
                o_ctl.tab_rd = tlca_pkg::T_PREV_V;
                n_state      = tlca_pkg::S_BK_RD2;
            end
            tlca_pkg::S_BK_RD2: begin
                o_ctl.tab_rd = tlca_pkg::T_PREV_MID;
                o_ctl.mid_ld = 1'b1;
                n_state      = tlca_pkg::S_BK_WR;
            end
            tlca_pkg::S_BK_WR: begin
                o_ctl.tab_wrk = 1'b1;
                n_state       = tlca_pkg::S_BK_RD1;
                if (i_stat.v_last) begin
                    o_ctl.v_one = 1'b1;
                    if (i_stat.k_last) begin
                        n_state = tlca_pkg::S_D_INIT;
                    end else begin
                        o_ctl.k_op = tlca_pkg::K_INC;
                    end
                end else begin
                    o_ctl.v_inc = 1'b1;
                end
            end
            // Depth of each node by lifting it to its root.
            tlca_pkg::S_D_INIT: begin
                o_ctl.d_init = 1'b1;
                o_ctl.k_op   = tlca_pkg::K_TOP;
                n_state      = tlca_pkg::S_D_RD;
            end
            tlca_pkg::S_D_RD: begin
                o_ctl.tab_rd = tlca_pkg::T_CUR;
                n_state      = tlca_pkg::S_D_STEP;
            end
            tlca_pkg::S_D_STEP: begin
                o_ctl.d_step = 1'b1;
                if (i_stat.k_zero) begin
                    n_state = tlca_pkg::S_D_WR;
                end else begin
                    o_ctl.k_op = tlca_pkg::K_DEC;
                    n_state    = tlca_pkg::S_D_RD;
                end
            end
            tlca_pkg::S_D_WR: begin
                o_ctl.dep_wr = 1'b1;
                if (i_stat.v_last) begin
                    o_ctl.set_built = 1'b1;
                    n_state         = tlca_pkg::S_Q_DA;
                end else begin
                    o_ctl.v_inc = 1'b1;
                    n_state     = tlca_pkg::S_D_INIT;
                end
            end
            // Query: fetch both depths and order the nodes.
            tlca_pkg::S_Q_DA: begin
                o_ctl.dep_rd_a = 1'b1;
                n_state        = tlca_pkg::S_Q_DB;
            end
            tlca_pkg::S_Q_DB: begin
                o_ctl.da_ld    = 1'b1;
                o_ctl.dep_rd_b = 1'b1;
                n_state        = tlca_pkg::S_Q_SW;
            end
            tlca_pkg::S_Q_SW: begin
                o_ctl.swap = 1'b1;
                o_ctl.k_op = tlca_pkg::K_ZERO;
                n_state    = tlca_pkg::S_L_CHK;
            end
            // Lift the deeper node by the depth difference.
            tlca_pkg::S_L_CHK: begin
                priority if (i_stat.a_zero) begin
                    n_state = tlca_pkg::S_M_CHK;
                end else if (i_stat.diff_bit) begin
                    o_ctl.tab_rd = tlca_pkg::T_A;
                    n_state      = tlca_pkg::S_L_UPD;
                end else if (i_stat.k_last) begin
                    n_state = tlca_pkg::S_M_CHK;
                end else begin
                    o_ctl.k_op = tlca_pkg::K_INC;
                end
            end
            tlca_pkg::S_L_UPD: begin
                o_ctl.lift_upd = 1'b1;
                if (i_stat.k_last) begin
                    n_state = tlca_pkg::S_M_CHK;
                end else begin
                    o_ctl.k_op = tlca_pkg::K_INC;
                    n_state    = tlca_pkg::S_L_CHK;
                end
            end
            tlca_pkg::S_M_CHK: begin
                priority if (i_stat.a_zero) begin
                    o_ctl.res_op = tlca_pkg::R_ZERO;
                    n_state      = tlca_pkg::S_RESULT;
                end else if (i_stat.a_eq_b) begin
                    o_ctl.res_op = tlca_pkg::R_A;
                    n_state      = tlca_pkg::S_RESULT;
                end else begin
                    o_ctl.k_op = tlca_pkg::K_TOP;
                    n_state    = tlca_pkg::S_M_RDA;
                end
            end
            // Lift both nodes together while their ancestors differ.
            tlca_pkg::S_M_RDA: begin
                o_ctl.tab_rd = tlca_pkg::T_A;
                n_state      = tlca_pkg::S_M_RDB;
            end
            tlca_pkg::S_M_RDB: begin
                o_ctl.ta_ld  = 1'b1;
                o_ctl.tab_rd = tlca_pkg::T_B;
                n_state      = tlca_pkg::S_M_CMP;
            end
            tlca_pkg::S_M_CMP: begin
                o_ctl.match_upd = 1'b1;
                if (i_stat.k_zero) begin
                    n_state = tlca_pkg::S_M_FIN;
                end else begin
                    o_ctl.k_op = tlca_pkg::K_DEC;
                    n_state    = tlca_pkg::S_M_RDA;
                end
            end
            tlca_pkg::S_M_FIN: begin
                o_ctl.tab_rd = tlca_pkg::T_A_LVL0;
                n_state      = tlca_pkg::S_M_RES;
            end
            tlca_pkg::S_M_RES: begin
                o_ctl.res_op = tlca_pkg::R_TAB;
                n_state      = tlca_pkg::S_RESULT;
            end
            tlca_pkg::S_RESULT: begin
                if (i_stat.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = tlca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tlca_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/tlca_datapath.sv =====
// ---------------------------------------------------------------------------
// Tree LCA datapath
// Parent store, ancestor table, depth store, counters and walk registers.
// ---------------------------------------------------------------------------
`default_nettype none

module tlca_datapath #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [tlca_pkg::ID_W-1:0] i_cfg_wdata,
    input  wire logic                      i_req_valid,
    input  wire logic                      i_req_cmd,
    input  wire logic [tlca_pkg::ID_W-1:0] i_req_a,
    input  wire logic [tlca_pkg::ID_W-1:0] i_req_b,
    input  wire tlca_pkg::t_ctrl           i_ctl,
    output tlca_pkg::t_stat                o_stat,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic      [tlca_pkg::ID_W-1:0] o_out_data
);

    localparam int IW     = tlca_pkg::ID_W;
    localparam int AW     = $clog2(NODES);
    localparam int LW     = $clog2(LEVELS);
    localparam int CW     = (AW > IW) ? AW : IW;
    localparam int TAW    = LW + AW;
    localparam int TDEPTH = LEVELS * (2 ** AW);

    logic [IW-1:0]     r_cnt;
    logic              r_built;
    logic              r_cmd;
    logic [IW-1:0]     r_a;
    logic [IW-1:0]     r_b;
    logic [AW-1:0]     r_v;
    logic [LW-1:0]     r_k;
    logic [AW-1:0]     r_clr;
    logic [IW-1:0]     r_mid;
    logic [IW-1:0]     r_ta;
    logic [IW-1:0]     r_cur;
    logic [LEVELS-1:0] r_d;
    logic [LEVELS-1:0] r_da;
    logic [LEVELS-1:0] r_diff;
    logic              r_tz;
    logic [IW-1:0]     r_res;
    logic              r_ov;
    logic [IW-1:0]     r_od;

    logic [CW-1:0]     live;
    logic              in_fire;
    logic [IW-1:0]     par_q;
    logic [IW-1:0]     tab_raw;
    logic [IW-1:0]     tq;
    logic [LEVELS-1:0] dep_q;
    logic              tab_re;
    logic [LW-1:0]     t_lvl;
    logic [AW-1:0]     t_node;
    logic              t_zero;
    logic [IW-1:0]     tab_wdata;
    logic [IW-1:0]     lvl0_data;

    // Count in use, capped at the last node the stores can hold.
    assign live    = (CW'(r_cnt) > CW'(NODES - 1)) ? CW'(NODES - 1) : CW'(r_cnt);
    assign in_fire = i_req_valid && i_ctl.take;

    // Node zero reads as "no ancestor" in every level.
    assign tq = r_tz ? '0 : tab_raw;

    // Ancestor table read address.
    always_comb begin
        tab_re = 1'b1;
        t_lvl  = r_k;
        t_node = AW'(r_a);
        t_zero = (r_a == '0);
        unique case (i_ctl.tab_rd)
            tlca_pkg::T_NONE: begin
                tab_re = 1'b0;
            end
            tlca_pkg::T_PREV_V: begin
                t_lvl  = r_k - LW'(1);
                t_node = r_v;
                t_zero = (r_v == '0);
            end
            tlca_pkg::T_PREV_MID: begin
                t_lvl  = r_k - LW'(1);
                t_node = AW'(tq);
                t_zero = (tq == '0);
            end
            tlca_pkg::T_CUR: begin
                t_node = AW'(r_cur);
                t_zero = (r_cur == '0);
            end
            tlca_pkg::T_A: begin
                t_node = AW'(r_a);
            end
            tlca_pkg::T_B: begin
                t_node = AW'(r_b);
                t_zero = (r_b == '0);
            end
            tlca_pkg::T_A_LVL0: begin
                t_lvl = '0;
            end
            default: begin
                tab_re = 1'b0;
            end
        endcase
    end

    // Table write data: level zero from the parent store, others doubled.
    assign lvl0_data = (CW'(par_q) <= live) ? par_q : '0;
    assign tab_wdata = i_ctl.tab_wr0 ? lvl0_data : ((r_mid != '0) ? tq : '0);

    tlca_ram #(
        .WIDTH (IW),
        .DEPTH (NODES)
    ) u_parent (
        .i_clk   (i_clk),
        .i_we    (i_ctl.clr_wr || i_ctl.edge_wr),
        .i_waddr (i_ctl.clr_wr ? r_clr : AW'(r_b)),
        .i_wdata (i_ctl.clr_wr ? '0 : r_a),
        .i_re    (i_ctl.par_rd),
        .i_raddr (r_v),
        .o_rdata (par_q)
    );

    tlca_ram #(
        .WIDTH (IW),
        .DEPTH (TDEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_ctl.tab_wr0 || i_ctl.tab_wrk),
        .i_waddr (TAW'({r_k, r_v})),
        .i_wdata (tab_wdata),
        .i_re    (tab_re),
        .i_raddr (TAW'({t_lvl, t_node})),
        .o_rdata (tab_raw)
    );

    tlca_ram #(
        .WIDTH (LEVELS),
        .DEPTH (NODES)
    ) u_depth (
        .i_clk   (i_clk),
        .i_we    (i_ctl.dep_wr),
        .i_waddr (r_v),
        .i_wdata (r_d),
        .i_re    (i_ctl.dep_rd_a || i_ctl.dep_rd_b),
        .i_raddr (i_ctl.dep_rd_b ? AW'(r_b) : AW'(r_a)),
        .o_rdata (dep_q)
    );

    // Control registers: count, build flag, sweep counter, result slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= IW'(1);
            r_built <= 1'b0;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cnt <= i_cfg_wdata;
            end
            if (i_cfg_we || i_ctl.edge_wr) begin
                r_built <= 1'b0;
            end else if (i_ctl.set_built) begin
                r_built <= 1'b1;
            end
            if (i_ctl.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_ctl.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Walk registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_req_cmd;
            r_a   <= i_req_a;
            r_b   <= i_req_b;
        end else if (i_ctl.swap && (r_da < dep_q)) begin
            r_a <= r_b;
            r_b <= r_a;
        end else if (i_ctl.lift_upd) begin
            r_a <= tq;
        end else if (i_ctl.match_upd && (r_ta != tq)) begin
            r_a <= r_ta;
            r_b <= tq;
        end

        if (i_ctl.v_one) begin
            r_v <= AW'(1);
        end else if (i_ctl.v_inc) begin
            r_v <= r_v + AW'(1);
        end

        unique case (i_ctl.k_op)
            tlca_pkg::K_HOLD: r_k <= r_k;
            tlca_pkg::K_ZERO: r_k <= '0;
            tlca_pkg::K_ONE:  r_k <= LW'(1);
            tlca_pkg::K_TOP:  r_k <= LW'(LEVELS - 1);
            tlca_pkg::K_INC:  r_k <= r_k + LW'(1);
            tlca_pkg::K_DEC:  r_k <= r_k - LW'(1);
            default:          r_k <= r_k;
        endcase

        if (tab_re) begin
            r_tz <= t_zero;
        end
        if (i_ctl.mid_ld) begin
            r_mid <= tq;
        end
        if (i_ctl.ta_ld) begin
            r_ta <= tq;
        end
        if (i_ctl.da_ld) begin
            r_da <= dep_q;
        end
        if (i_ctl.swap) begin
            r_diff <= (r_da < dep_q) ? (dep_q - r_da) : (r_da - dep_q);
        end

        // Depth accumulation: one level per step, highest first.
        if (i_ctl.d_init) begin
            r_cur <= IW'(r_v);
            r_d   <= '0;
        end else if (i_ctl.d_step && (tq != '0)) begin
            r_cur <= tq;
            r_d   <= r_d | (LEVELS'(1) << r_k);
        end

        unique case (i_ctl.res_op)
            tlca_pkg::R_HOLD: r_res <= r_res;
            tlca_pkg::R_ZERO: r_res <= '0;
            tlca_pkg::R_A:    r_res <= r_a;
            tlca_pkg::R_TAB:  r_res <= tq;
            default:          r_res <= r_res;
        endcase

        if (i_ctl.out_load) begin
            r_od <= r_res;
        end
    end

    // Status back to the controller.
    always_comb begin
        o_stat.in_fire  = in_fire;
        o_stat.clr_last = (r_clr == AW'(NODES - 1));
        o_stat.v_last   = (CW'(r_v) >= live);
        o_stat.k_last   = (r_k == LW'(LEVELS - 1));
        o_stat.k_zero   = (r_k == '0);
        o_stat.is_query = (r_cmd == tlca_pkg::CMD_QUERY);
        o_stat.ids_ok   = (r_a != '0) && (CW'(r_a) <= live)
                       && (r_b != '0) && (CW'(r_b) <= live);
        o_stat.built    = r_built;
        o_stat.diff_bit = r_diff[r_k];
        o_stat.a_zero   = (r_a == '0);
        o_stat.a_eq_b   = (r_a == r_b);
        o_stat.out_free = !r_ov || i_out_ready;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

endmodule

`default_nettype wire

// ===== sv/tlca_checker.sv =====
// ---------------------------------------------------------------------------
// Tree LCA port checker
// Port-level properties of the core, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tree_lowest_common_ancestor_core_defines.svh"

module tlca_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic i_req_ready,
    input wire logic i_rsp_valid,
    input wire logic i_rsp_ready
);

    // A pending result stays offered until taken.
    `TLCA_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid, "result dropped")
    // One item at a time: no item is taken right after another.
    `TLCA_ASSERT_NEXT(a_one_item, i_req_valid && i_req_ready, !i_req_ready, "item overlap")
    // The clearing pass keeps the request side closed after reset.
    `TLCA_ASSERT_NEXT_RST(a_rst_ready, !i_rst_n, !i_req_ready, "ready during clear")
    // No result is offered right after reset.
    `TLCA_ASSERT_NEXT_RST(a_rst_valid, !i_rst_n, !i_rsp_valid, "result after reset")

endmodule

bind tree_lowest_common_ancestor_core tlca_checker u_tlca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready)
);

`default_nettype wire

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// Tree lowest common ancestor core testbench
// Drives edge and query items through the request channel, predicts each
// answer with a binary lifting model of its own, and checks every response
// item in order. Random idling on both channels, several node counts.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int NODES     = 1024;
    localparam int LEVELS    = 10;
    localparam int ID_W      = tlca_pkg::ID_W;
    localparam int MAX_ID    = NODES - 1;
    localparam int CYCLE_CAP = 1500000;

    typedef tlca_pkg::t_cmd t_cmd;
    localparam t_cmd CMD_LINK  = tlca_pkg::CMD_LINK;
    localparam t_cmd CMD_QUERY = tlca_pkg::CMD_QUERY;

    typedef struct packed {
        t_cmd            cmd;
        logic [ID_W-1:0] node_a;
        logic [ID_W-1:0] node_b;
    } t_item;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [ID_W-1:0] i_cfg_wdata;

    tlca_req_if req_bus ();
    tlca_rsp_if rsp_bus ();

    tree_lowest_common_ancestor_core #(
        .NODES (NODES),
        .LEVELS(LEVELS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus)
    );

    // Clock with a period of 8.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Shadow tree state for the predictor.
    logic [ID_W-1:0] tree_count;
    logic [ID_W-1:0] parent_of [NODES];
    logic [ID_W-1:0] lift_tab  [NODES][LEVELS];
    int unsigned     depth_of  [NODES];
    bit              lift_ready;

    t_item           pending_items [$];
    logic [ID_W-1:0] ancestor_queue[$];
    int              fail_count;
    int              cycle_count;
    bit              req_taken;
    bit              rsp_taken;
    bit              no_idle;
    int              send_gap;
    int              recv_stall;

    function automatic int unsigned live_count();
        return (tree_count < MAX_ID) ? tree_count : MAX_ID;
    endfunction

    function automatic bit id_valid(logic [ID_W-1:0] v);
        return (v >= 1) && (v <= live_count());
    endfunction

    // Rebuild the doubling table and node depths from the parent store.
    function automatic void rebuild_lift();
        int unsigned n;
        int unsigned cur;
        int unsigned d;
        logic [ID_W-1:0] mid;
        n = live_count();
        for (int v = 1; v <= n; v++) begin
            lift_tab[v][0] = (parent_of[v] <= n) ? parent_of[v] : '0;
        end
        for (int k = 1; k < LEVELS; k++) begin
            for (int v = 1; v <= n; v++) begin
                mid = lift_tab[v][k-1];
                lift_tab[v][k] = (mid != 0) ? lift_tab[mid][k-1] : '0;
            end
        end
        for (int v = 1; v <= n; v++) begin
            cur = v;
            d = 0;
            for (int k = LEVELS - 1; k >= 0; k--) begin
                if (lift_tab[cur][k] != 0) begin
                    cur = lift_tab[cur][k];
                    d += (1 << k);
                end
            end
            depth_of[v] = d;
        end
        lift_ready = 1'b1;
    endfunction

    // Lowest common ancestor by lifting to equal depth, then together.
    function automatic logic [ID_W-1:0] common_ancestor_of(logic [ID_W-1:0] a,
                                                           logic [ID_W-1:0] b);
        logic [ID_W-1:0] t;
        int unsigned     diff;
        if (depth_of[a] < depth_of[b]) begin
            t = a;
            a = b;
            b = t;
        end
        diff = depth_of[a] - depth_of[b];
        for (int k = 0; k < LEVELS && a != 0; k++) begin
            if ((diff >> k) & 1) a = lift_tab[a][k];
        end
        if (a == 0) return '0;
        if (a == b) return a;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            if (lift_tab[a][k] != lift_tab[b][k]) begin
                a = lift_tab[a][k];
                b = lift_tab[b][k];
            end
        end
        return lift_tab[a][0];
    endfunction

    // Apply one accepted item to the shadow state.
    function automatic void predict_item(t_item it);
        if (it.cmd == CMD_LINK) begin
            if (id_valid(it.node_a) && id_valid(it.node_b)) begin
                parent_of[it.node_b] = it.node_a;
                lift_ready = 1'b0;
            end
        end else if (!id_valid(it.node_a) || !id_valid(it.node_b)) begin
            ancestor_queue.insert(ancestor_queue.size(), '0);
        end else begin
            if (!lift_ready) rebuild_lift();
            ancestor_queue.insert(ancestor_queue.size(),
                                  common_ancestor_of(it.node_a, it.node_b));
        end
    endfunction

    // Monitor: check response items, then predict accepted request items.
    always @(posedge i_clk) begin
        req_taken = 1'b0;
        rsp_taken = 1'b0;
        if (i_rst_n) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                rsp_taken = 1'b1;
                if (ancestor_queue.size() == 0) begin
                    $error("common_ancestor: no item expected, actual %0d",
                           rsp_bus.common_ancestor);
                    fail_count++;
                end else begin
                    if (rsp_bus.common_ancestor !== ancestor_queue[0]) begin
                        $error("common_ancestor: expected %0d, actual %0d",
                               ancestor_queue[0], rsp_bus.common_ancestor);
                        fail_count++;
                    end
                    void'(ancestor_queue.pop_front());
                end
            end
            if (req_bus.valid && req_bus.ready) begin
                req_taken = 1'b1;
                predict_item('{t_cmd'(req_bus.cmd), req_bus.node_a, req_bus.node_b});
            end
        end
    end

    // Driver: present queued items with random gaps between them.
    always @(negedge i_clk) begin
        logic  nxt_valid;
        t_item nxt;
        nxt_valid = req_bus.valid && !req_taken;
        nxt = '{t_cmd'(req_bus.cmd), req_bus.node_a, req_bus.node_b};
        if (i_rst_n && !nxt_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_items.size() != 0) begin
                nxt = pending_items.pop_front();
                nxt_valid = 1'b1;
                send_gap = no_idle ? 0 : $urandom_range(0, 4);
            end
        end
        req_bus.valid  <= nxt_valid;
        req_bus.cmd    <= nxt.cmd;
        req_bus.node_a <= nxt.node_a;
        req_bus.node_b <= nxt.node_b;
    end

    // Receiver: random stall before each response item.
    always @(negedge i_clk) begin
        if (rsp_taken) recv_stall = no_idle ? 0 : $urandom_range(0, 4);
        else if (recv_stall > 0) recv_stall--;
        rsp_bus.ready <= i_rst_n && (recv_stall == 0);
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("tree_lowest_common_ancestor_core test failed");
            $finish;
        end
    end

    task automatic push_item(t_cmd c, int a, int b);
        t_item it;
        it = '{c, ID_W'(a), ID_W'(b)};
        pending_items.insert(pending_items.size(), it);
    endtask

    // Wait until every item is sent and answered, plus a few spare cycles.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || req_bus.valid || ancestor_queue.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_count(int value);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ID_W'(value);
        tree_count = ID_W'(value);
        lift_ready = 1'b0;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random tree over 1..n: mostly parent below child, a few arbitrary links.
    task automatic push_tree(int n);
        for (int c = 2; c <= n; c++) begin
            if ($urandom_range(0, 49) == 0) push_item(CMD_LINK, $urandom_range(1, n), c);
            else push_item(CMD_LINK, $urandom_range(1, c - 1), c);
        end
    endtask

    // Mostly valid queries, some stray links and out-of-range noise.
    task automatic push_mix(int n, int count, int link_pct);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) push_item(t_cmd'($urandom_range(0, 1)), $urandom_range(0, MAX_ID),
                                 $urandom_range(0, MAX_ID));
            else if (r < 8 + link_pct)
                push_item(CMD_LINK, $urandom_range(1, n), $urandom_range(1, n));
            else push_item(CMD_QUERY, $urandom_range(1, n), $urandom_range(1, n));
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        req_bus.valid  = 1'b0;
        req_bus.cmd    = CMD_LINK;
        req_bus.node_a = '0;
        req_bus.node_b = '0;
        rsp_bus.ready  = 1'b0;
        fail_count     = 0;
        cycle_count    = 0;
        no_idle        = 1'b0;
        send_gap       = 0;
        recv_stall     = 0;
        tree_count     = 1;
        lift_ready     = 1'b0;
        for (int v = 0; v < NODES; v++) begin
            parent_of[v] = '0;
            depth_of[v]  = 0;
            for (int k = 0; k < LEVELS; k++) lift_tab[v][k] = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Single node after reset, a self loop, and invalid ids.
        push_item(CMD_QUERY, 1, 1);
        push_item(CMD_QUERY, 0, 1);
        push_item(CMD_QUERY, MAX_ID, MAX_ID);
        push_item(CMD_LINK, 1, 1);
        push_item(CMD_QUERY, 1, 1);

        // Small forest with a repeated child and ignored links.
        write_count(8);
        push_item(CMD_LINK, 1, 2);
        push_item(CMD_LINK, 1, 3);
        push_item(CMD_LINK, 2, 4);
        push_item(CMD_LINK, 3, 4);
        push_item(CMD_LINK, 2, 5);
        push_item(CMD_LINK, 8, 6);
        push_item(CMD_LINK, 0, 3);
        push_item(CMD_LINK, 9, 2);
        push_item(CMD_LINK, MAX_ID, MAX_ID);
        push_item(CMD_QUERY, 4, 5);
        push_item(CMD_QUERY, 5, 2);
        push_item(CMD_QUERY, 6, 4);
        push_item(CMD_QUERY, 7, 7);
        push_item(CMD_QUERY, 0, 0);
        push_item(CMD_QUERY, 3, 9);
        push_item(CMD_LINK, 4, 1);
        push_item(CMD_QUERY, 5, 3);

        // Shrinking the count leaves node 6 with a stale parent.
        write_count(5);
        push_item(CMD_QUERY, 4, 5);
        push_item(CMD_QUERY, 6, 1);
        push_item(CMD_QUERY, 1, 2);

        // Random trees of several sizes; one stretch without idling.
        write_count(30);
        no_idle = 1'b1;
        push_tree(30);
        push_mix(30, 150, 4);
        drain();
        no_idle = 1'b0;

        write_count(200);
        push_tree(200);
        push_mix(200, 200, 1);

        write_count(12);
        push_tree(12);
        push_mix(12, 150, 6);

        // Largest count: a short chain plus a few random links, then queries.
        write_count(MAX_ID);
        for (int i = 0; i < 30; i++) push_item(CMD_LINK, MAX_ID - i - 1, MAX_ID - i);
        for (int i = 0; i < 10; i++)
            push_item(CMD_LINK, $urandom_range(1, MAX_ID), $urandom_range(1, MAX_ID));
        for (int i = 0; i < 60; i++) begin
            if (i % 4 == 0) push_item(CMD_QUERY, MAX_ID, $urandom_range(MAX_ID - 40, MAX_ID));
            else push_item(CMD_QUERY, $urandom_range(1, MAX_ID), $urandom_range(1, MAX_ID));
        end

        write_count(1);
        push_mix(1, 40, 10);

        write_count(60);
        push_tree(60);
        push_mix(60, 150, 3);

        drain();
        if (fail_count == 0) begin
            $display("tree_lowest_common_ancestor_core test passed");
        end else begin
            $display("tree_lowest_common_ancestor_core test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
